/* design/ncrs_pkg.sv */
// ----------------------------------------------------------------------------
// Newton cubic root solver package
// Shared types, constants and the saturating adder for the root solver.
// ----------------------------------------------------------------------------
package ncrs_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int VAL_W = 32;
	localparam int MAG_W = 63;
	localparam int TOL_W = 31;
	localparam int ITER_W = 10;
	localparam int IDX_W = 1;

	localparam logic [IDX_W-1:0] REG_TOLERANCE = 1'b0;
	localparam logic [IDX_W-1:0] REG_ITER_LIMIT = 1'b1;

	localparam logic signed [63:0] SAT64 = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		STAT_CONVERGED  = 2'd0,
		STAT_LIMIT      = 2'd1,
		STAT_ZERO_DERIV = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_X2   = 3'd0,
		OP_P97  = 3'd1,
		OP_X3   = 3'd2,
		OP_P13  = 3'd3,
		OP_P3   = 3'd4,
		OP_P194 = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_MGO  = 3'd1,
		ST_MUL  = 3'd2,
		ST_ACC  = 3'd3,
		ST_ADJ  = 3'd4,
		ST_CHK  = 3'd5,
		ST_DIV  = 3'd6,
		ST_UPD  = 3'd7
	} state_t;

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > SUM_MAX) begin
			sadd = SAT64;
		end else if (s < -SUM_MAX) begin
			sadd = -SAT64;
		end else begin
			sadd = s[63:0];
		end
	endfunction

endpackage

/* design/ncrs_mul.sv */
// ----------------------------------------------------------------------------
// Serial magnitude multiplier
// Shift-and-add multiplier taking one multiplier bit per cycle, followed by
// rounding to the fixed-point scale and saturation of the magnitude.
// ----------------------------------------------------------------------------
module ncrs_mul import ncrs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [MAG_W-1:0] ma,
	input  logic [VAL_W-1:0] mb,
	output logic             done,
	output logic [MAG_W-1:0] res
);

	localparam int PW = MAG_W + VAL_W;
	localparam int CW = $clog2(VAL_W);
	localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRAC_BITS - 1);

	logic [PW-1:0]    acc_q;
	logic [MAG_W-1:0] ma_q;
	logic [VAL_W-1:0] mb_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             fin_q;
	logic             done_q;
	logic [MAG_W-1:0] res_q;

	logic [MAG_W:0] sum;
	logic [PW:0]    rnd;
	logic [PW:0]    shifted;

	always_comb begin
		sum = {1'b0, acc_q[PW-1:VAL_W]} + (mb_q[0] ? {1'b0, ma_q} : '0);
		rnd = {1'b0, acc_q} + HALF;
		shifted = rnd >> FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q && !go && !run_q;
			if (go) begin
				run_q <= 1'b1;
				fin_q <= 1'b0;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(VAL_W - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			ma_q <= ma;
			mb_q <= mb;
		end else if (run_q) begin
			acc_q <= {sum, acc_q[VAL_W-1:1]};
			mb_q <= mb_q >> 1;
		end else if (fin_q) begin
			res_q <= (|shifted[PW:MAG_W]) ? '1 : shifted[MAG_W-1:0];
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

/* design/ncrs_div.sv */
// ----------------------------------------------------------------------------
// Serial restoring divider
// Computes the scaled quotient of two magnitudes one quotient bit per cycle
// and saturates it to the largest positive intermediate.
// ----------------------------------------------------------------------------
module ncrs_div import ncrs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [MAG_W-1:0] mn,
	input  logic [MAG_W-1:0] md,
	output logic             done,
	output logic [MAG_W-1:0] res
);

	localparam int DW = MAG_W + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0]    dvd_q;
	logic [MAG_W-1:0] md_q;
	logic [MAG_W-1:0] r_q;
	logic [MAG_W-1:0] q_q;
	logic             ovf_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             fin_q;
	logic             done_q;
	logic [MAG_W-1:0] res_q;

	logic [MAG_W:0]   rs;
	logic             ge;
	logic [MAG_W:0]   diff;

	always_comb begin
		rs = {r_q, dvd_q[DW-1]};
		ge = rs >= {1'b0, md_q};
		diff = rs - {1'b0, md_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q && !go && !run_q;
			if (go) begin
				run_q <= 1'b1;
				fin_q <= 1'b0;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= {mn, {FRAC_BITS{1'b0}}};
			md_q <= md;
			r_q <= '0;
			q_q <= '0;
			ovf_q <= 1'b0;
		end else if (run_q) begin
			dvd_q <= dvd_q << 1;
			r_q <= ge ? diff[MAG_W-1:0] : rs[MAG_W-1:0];
			ovf_q <= ovf_q | q_q[MAG_W-1];
			q_q <= {q_q[MAG_W-2:0], ge};
		end else if (fin_q) begin
			res_q <= ovf_q ? '1 : q_q;
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

/* design/newton_cubic_root_solver_top.sv */
// ----------------------------------------------------------------------------
// Newton cubic root solver
// Newton-Raphson iteration on -x^3 + 9.7x^2 - 1.3x - 105.7 in signed fixed
// point, with a serial multiplier and a serial divider under one sequencer.
// ----------------------------------------------------------------------------
// Pulse start with a starting guess while busy is low. If the iteration
// limit is not zero, the block raises busy on the next cycle and keeps it
// high until the answer is ready. The result word then appears on root,
// iterations_used, final_error and status for one cycle, marked by done;
// the receiver must take it in that cycle. The tolerance and iteration
// limit are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle, which the block itself does
// not enforce, and they then take effect on the next start. One iteration
// runs six products on the serial multiplier, a step that adds the
// constant terms and, unless the derivative is zero, one division followed
// by the update. A zero derivative ends the guess in the iteration that
// finds it, before the division. With a limit of zero the result comes
// back in the cycle after start.
// Reset returns the block to idle, sets the tolerance to 66 and the limit to
// 100, and drops done and busy.
// ----------------------------------------------------------------------------
module newton_cubic_root_solver_top import ncrs_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [VAL_W-1:0]  start_guess,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [TOL_W-1:0]         cfg_data,
	output logic                     done,
	output logic signed [VAL_W-1:0]  root,
	output logic [ITER_W-1:0]        iterations_used,
	output logic [TOL_W-1:0]         final_error,
	output logic [1:0]               status
);

	localparam longint ONE = longint'(1) << FRAC_BITS;
	localparam logic [VAL_W-1:0] C97 = VAL_W'((97 * ONE + 5) / 10);
	localparam logic [VAL_W-1:0] C13 = VAL_W'((13 * ONE + 5) / 10);
	localparam logic [VAL_W-1:0] C3 = VAL_W'(3 * ONE);
	localparam logic [VAL_W-1:0] C194 = VAL_W'((194 * ONE + 5) / 10);
	localparam logic signed [63:0] C105_S = 64'((1057 * ONE + 5) / 10);
	localparam logic signed [63:0] C13_S = 64'((13 * ONE + 5) / 10);

	state_t state_q, state_d;
	op_t    op_q;

	logic [TOL_W-1:0]        tol_q;
	logic [ITER_W-1:0]       limit_q;
	logic signed [VAL_W-1:0] x_q;
	logic [MAG_W-1:0]        x2_q;
	logic signed [63:0]      fx_q;
	logic signed [63:0]      dfx_q;
	logic                    dneg_q;
	logic [ITER_W-1:0]       used_q;
	logic [TOL_W-1:0]        err_q;
	status_t                 status_q;
	logic                    done_q;
	logic                    done_d;

	logic                    mul_go;
	logic [MAG_W-1:0]        mul_a;
	logic [VAL_W-1:0]        mul_b;
	logic                    mul_neg;
	logic                    mul_done;
	logic [MAG_W-1:0]        mul_res;
	logic signed [63:0]      mval;

	logic                    div_go;
	logic                    div_done;
	logic [MAG_W-1:0]        div_res;

	logic [VAL_W-1:0]        xmag;
	logic [MAG_W-1:0]        fx_mag;
	logic [MAG_W-1:0]        dfx_mag;
	logic signed [64:0]      h;
	logic signed [65:0]      nx;
	logic signed [VAL_W-1:0] nx_c;
	logic [TOL_W-1:0]        err_new;
	logic [ITER_W-1:0]       used_new;
	logic                    conv;
	logic                    last;
	logic                    dfx_zero;

	always_comb begin
		xmag = x_q[VAL_W-1] ? VAL_W'(-x_q) : VAL_W'(x_q);
		fx_mag = fx_q[63] ? MAG_W'(-fx_q) : fx_q[MAG_W-1:0];
		dfx_mag = dfx_q[63] ? MAG_W'(-dfx_q) : dfx_q[MAG_W-1:0];
		dfx_zero = dfx_q == '0;

		mul_a = x2_q;
		mul_b = xmag;
		mul_neg = 1'b0;
		case (op_q)
			OP_X2: begin
				mul_a = MAG_W'(xmag);
			end
			OP_P97: begin
				mul_b = C97;
			end
			OP_X3: begin
				mul_neg = x_q[VAL_W-1];
			end
			OP_P13: begin
				mul_a = MAG_W'(xmag);
				mul_b = C13;
				mul_neg = x_q[VAL_W-1];
			end
			OP_P3: begin
				mul_b = C3;
			end
			OP_P194: begin
				mul_a = MAG_W'(xmag);
				mul_b = C194;
				mul_neg = x_q[VAL_W-1];
			end
			default: begin
				mul_a = x2_q;
			end
		endcase
		mval = mul_neg ? -$signed({1'b0, mul_res}) : $signed({1'b0, mul_res});

		h = dneg_q ? -$signed({2'b00, div_res}) : $signed({2'b00, div_res});
		nx = {{(66 - VAL_W){x_q[VAL_W-1]}}, x_q} - {h[64], h};
		if (nx > 66'sd2147483647) begin
			nx_c = 32'sh7FFF_FFFF;
		end else if (nx < -66'sd2147483648) begin
			nx_c = 32'sh8000_0000;
		end else begin
			nx_c = nx[VAL_W-1:0];
		end
		err_new = (|div_res[MAG_W-1:TOL_W]) ? '1 : div_res[TOL_W-1:0];
		used_new = used_q + 1'b1;
		conv = err_new < tol_q;
		last = used_new == limit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_go = 1'b0;
		div_go = 1'b0;
		done_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (limit_q != '0) begin
						state_d = ST_MGO;
					end else begin
						done_d = 1'b1;
					end
				end
			end
			ST_MGO: begin
				mul_go = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (mul_done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				state_d = (op_q == OP_P194) ? ST_ADJ : ST_MGO;
			end
			ST_ADJ: begin
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (dfx_zero) begin
					done_d = 1'b1;
					state_d = ST_IDLE;
				end else begin
					div_go = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				done_d = conv || last;
				state_d = (conv || last) ? ST_IDLE : ST_MGO;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_W'(66);
			limit_q <= ITER_W'(100);
			done_q <= 1'b0;
			status_q <= STAT_LIMIT;
			op_q <= OP_X2;
			used_q <= '0;
		end else begin
			done_q <= done_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_TOLERANCE: tol_q <= cfg_data;
					REG_ITER_LIMIT: limit_q <= cfg_data[ITER_W-1:0];
					default: tol_q <= tol_q;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q <= OP_X2;
						used_q <= '0;
						if (limit_q == '0) begin
							status_q <= STAT_LIMIT;
						end
					end
				end
				ST_ACC: begin
					op_q <= (op_q == OP_P194) ? OP_X2 : op_t'(op_q + 1'b1);
				end
				ST_CHK: begin
					if (dfx_zero) begin
						status_q <= STAT_ZERO_DERIV;
					end
				end
				ST_UPD: begin
					used_q <= used_new;
					if (conv) begin
						status_q <= STAT_CONVERGED;
					end else if (last) begin
						status_q <= STAT_LIMIT;
					end
				end
				default: begin
					op_q <= op_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					x_q <= start_guess;
					err_q <= '0;
				end
			end
			ST_ACC: begin
				case (op_q)
					OP_X2: x2_q <= mul_res;
					OP_P97: fx_q <= mval;
					OP_X3: fx_q <= sadd(fx_q, -mval);
					OP_P13: fx_q <= sadd(fx_q, -mval);
					OP_P3: dfx_q <= -mval;
					OP_P194: dfx_q <= sadd(dfx_q, mval);
					default: x2_q <= x2_q;
				endcase
			end
			ST_ADJ: begin
				fx_q <= sadd(fx_q, -C105_S);
				dfx_q <= sadd(dfx_q, -C13_S);
			end
			ST_CHK: begin
				dneg_q <= fx_q[63] ^ dfx_q[63];
			end
			ST_UPD: begin
				x_q <= nx_c;
				err_q <= err_new;
			end
			default: begin
				x_q <= x_q;
			end
		endcase
	end

	ncrs_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.go(mul_go),
		.ma(mul_a),
		.mb(mul_b),
		.done(mul_done),
		.res(mul_res)
	);

	ncrs_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(div_go),
		.mn(fx_mag),
		.md(dfx_mag),
		.done(div_done),
		.res(div_res)
	);

	assign busy = state_q != ST_IDLE;
	assign done = done_q;
	assign root = x_q;
	assign iterations_used = used_q;
	assign final_error = err_q;
	assign status = status_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result word shown while the sequencer is still running");

	a_conv_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == STAT_CONVERGED) |-> used_q != '0)
		else $error("converged result with no iteration counted");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> used_q <= limit_q)
		else $error("iteration count beyond the limit");

	a_start_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done_q))
		else $error("accepted guess neither started nor answered");
`endif

endmodule
